// File: design/met_pkg.sv
// Shared types, constants and the coordinate saturation helper for the
// Mandelbrot escape-time block. No dependencies.
package met_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int COORD_W     = FRAC_BITS + 4;
  localparam int SQ_W        = 2 * COORD_W;
  localparam int ORIGIN_BITS = 13;
  localparam int STEP_BITS   = 29;
  localparam int OUT_ITER_W  = 16;
  localparam int IDX_W       = 3;
  localparam int RE_W        = SQ_W - FRAC_BITS;
  localparam int IM_W        = SQ_W + 1 - FRAC_BITS;

  // |z|^2 bound of 4 at the scale of a product of two coordinates
  localparam logic [SQ_W-1:0] ESC_LIMIT = SQ_W'(1) << (2 * FRAC_BITS + 2);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [STEP_BITS-1:0] RST_STEP = STEP_BITS'(262144);
  localparam int RST_MAX_ITER = 256;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_STEP_X   = 3'd2,
    REG_STEP_Y   = 3'd3,
    REG_MAX_ITER = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic load_in;
    logic map_en;
    logic init_en;
    logic mul_en;
    logic sum_en;
    logic upd_en;
    logic res_load;
  } met_cmd_t;

  typedef struct packed {
    logic go;
  } met_sts_t;

  // Clamp a wide signed value into the Q4 coordinate range.
  function automatic coord_t sat_coord(input logic signed [SQ_W-1:0] v);
    coord_t res;
    if (v > SQ_W'(COORD_MAX)) begin
      res = COORD_MAX;
    end else if (v < SQ_W'(COORD_MIN)) begin
      res = COORD_MIN;
    end else begin
      res = COORD_W'(v);
    end
    return res;
  endfunction

endpackage

// File: design/met_cfg.sv
// Configuration register file: origin, step and iteration limit.
// Depends on met_pkg.
module met_cfg
  import met_pkg::*;
#(
  parameter int ITER_BITS = 16,
  parameter int CFG_W     = 29
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [IDX_W-1:0]              cfg_idx,
  input  logic [CFG_W-1:0]              cfg_wdata,
  output logic signed [ORIGIN_BITS-1:0] origin_x,
  output logic signed [ORIGIN_BITS-1:0] origin_y,
  output logic [STEP_BITS-1:0]          step_x,
  output logic [STEP_BITS-1:0]          step_y,
  output logic [ITER_BITS-1:0]          max_iter
);

  logic signed [ORIGIN_BITS-1:0] origin_x_r;
  logic signed [ORIGIN_BITS-1:0] origin_y_r;
  logic [STEP_BITS-1:0]          step_x_r;
  logic [STEP_BITS-1:0]          step_y_r;
  logic [ITER_BITS-1:0]          max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      step_x_r   <= RST_STEP;
      step_y_r   <= RST_STEP;
      max_iter_r <= ITER_BITS'(RST_MAX_ITER);
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_idx))
        REG_ORIGIN_X: origin_x_r <= $signed(cfg_wdata[ORIGIN_BITS-1:0]);
        REG_ORIGIN_Y: origin_y_r <= $signed(cfg_wdata[ORIGIN_BITS-1:0]);
        REG_STEP_X:   step_x_r   <= cfg_wdata[STEP_BITS-1:0];
        REG_STEP_Y:   step_y_r   <= cfg_wdata[STEP_BITS-1:0];
        REG_MAX_ITER: max_iter_r <= cfg_wdata[ITER_BITS-1:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  assign origin_x = origin_x_r;
  assign origin_y = origin_y_r;
  assign step_x   = step_x_r;
  assign step_y   = step_y_r;
  assign max_iter = max_iter_r;

endmodule

// File: design/met_ctrl.sv
// Sequencer for one pixel: map, then multiply / reduce / update per iteration.
// Depends on met_pkg; drives the datapath through met_cmd_t.
module met_ctrl
  import met_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output met_cmd_t cmd,
  input  met_sts_t sts
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MAP  = 6'b000010,
    S_INIT = 6'b000100,
    S_MUL  = 6'b001000,
    S_SUM  = 6'b010000,
    S_DEC  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MAP;
        end
      end
      S_MAP: begin
        cmd.map_en = 1'b1;
        state_nxt  = S_INIT;
      end
      S_INIT: begin
        cmd.init_en = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_nxt  = S_DEC;
      end
      S_DEC: begin
        if (sts.go) begin
          cmd.upd_en = 1'b1;
          state_nxt  = S_MUL;
        end else if (!out_valid_r || !out_stall) begin
          // hold here until the output word is free
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: design/met_dp.sv
// Datapath: pixel mapping, squaring multipliers, escape test, z update,
// iteration counter and output word register. Depends on met_pkg.
module met_dp
  import met_pkg::*;
#(
  parameter int PIXEL_BITS = 12,
  parameter int ITER_BITS  = 16
) (
  input  logic                          clk,
  input  met_cmd_t                      cmd,
  output met_sts_t                      sts,
  input  logic [PIXEL_BITS-1:0]         pixel_x,
  input  logic [PIXEL_BITS-1:0]         pixel_y,
  input  logic signed [ORIGIN_BITS-1:0] origin_x,
  input  logic signed [ORIGIN_BITS-1:0] origin_y,
  input  logic [STEP_BITS-1:0]          step_x,
  input  logic [STEP_BITS-1:0]          step_y,
  input  logic [ITER_BITS-1:0]          max_iter,
  output logic [OUT_ITER_W-1:0]         iterations,
  output logic                          inside_res
);

  localparam int DIFF_W =
    ((PIXEL_BITS + 1 > ORIGIN_BITS) ? PIXEL_BITS + 1 : ORIGIN_BITS) + 1;
  localparam int PROD_W = DIFF_W + STEP_BITS + 1;

  logic signed [DIFF_W-1:0] diff_x_r, diff_y_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r;
  coord_t                   cx_r, cy_r, zx_r, zy_r;
  logic signed [SQ_W-1:0]   xx_r, yy_r, xy_r;
  logic                     bnd_r;
  logic signed [RE_W-1:0]   re_r;
  logic signed [IM_W-1:0]   im_r;
  logic [ITER_BITS-1:0]     count_r;
  logic [OUT_ITER_W-1:0]    res_iter_r;
  logic                     res_inside_r;

  logic [SQ_W-1:0]          mag_sum;
  logic signed [SQ_W-1:0]   sq_diff;
  logic [31:0]              count_ext;

  // squares are non-negative, so their sum is the |z|^2 magnitude
  assign mag_sum   = $unsigned(xx_r) + $unsigned(yy_r);
  assign sq_diff   = xx_r - yy_r;
  assign count_ext = 32'(count_r);

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      diff_x_r <= DIFF_W'($signed({1'b0, pixel_x})) - DIFF_W'(origin_x);
      diff_y_r <= DIFF_W'($signed({1'b0, pixel_y})) - DIFF_W'(origin_y);
    end
    if (cmd.map_en) begin
      prod_x_r <= diff_x_r * $signed({1'b0, step_x});
      prod_y_r <= diff_y_r * $signed({1'b0, step_y});
    end
    if (cmd.init_en) begin
      cx_r    <= sat_coord(SQ_W'(prod_x_r));
      cy_r    <= sat_coord(SQ_W'(prod_y_r));
      zx_r    <= sat_coord(SQ_W'(prod_x_r));
      zy_r    <= sat_coord(SQ_W'(prod_y_r));
      count_r <= '0;
    end
    if (cmd.mul_en) begin
      xx_r <= zx_r * zx_r;
      yy_r <= zy_r * zy_r;
      xy_r <= zx_r * zy_r;
    end
    if (cmd.sum_en) begin
      bnd_r <= (mag_sum <= ESC_LIMIT);
      re_r  <= RE_W'(sq_diff >>> FRAC_BITS);
      // 2xy rescaled: shift by one bit less
      im_r  <= IM_W'(xy_r >>> (FRAC_BITS - 1));
    end
    if (cmd.upd_en) begin
      zx_r    <= sat_coord(SQ_W'(re_r) + SQ_W'(cx_r));
      zy_r    <= sat_coord(SQ_W'(im_r) + SQ_W'(cy_r));
      count_r <= count_r + ITER_BITS'(1);
    end
    if (cmd.res_load) begin
      res_iter_r   <= count_ext[OUT_ITER_W-1:0];
      res_inside_r <= (count_r == max_iter);
    end
  end

  assign sts.go     = bnd_r && (count_r < max_iter);
  assign iterations = res_iter_r;
  assign inside_res = res_inside_r;

endmodule

// File: design/mandelbrot_escape_time_top.sv
// Top level of the Mandelbrot escape-time evaluator.
// Depends on met_pkg, met_cfg, met_ctrl and met_dp.
//
//   channel  direction  handshake            word
//   in_      input      in_valid / in_stall  pixel_x, pixel_y
//   out_     output     out_valid/out_stall  iterations, inside_res
//   cfg_     input      cfg_valid/cfg_ready  cfg_idx, cfg_wdata
//
// A pixel is accepted only in the idle state, once the last pixel is done;
// each iteration is one pass of multiply, reduce and update
// through the three squaring multipliers. Reset (rst_n low, synchronous)
// restores the register defaults and empties the block. A finished word waits
// in the output register while the next pixel is taken; a stalled output only
// holds the block once the following pixel is ready to leave.
module mandelbrot_escape_time_top
  import met_pkg::*;
#(
  parameter int PIXEL_BITS = 12,
  parameter int ITER_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [PIXEL_BITS-1:0]                  in_pixel_x,
  input  logic [PIXEL_BITS-1:0]                  in_pixel_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [OUT_ITER_W-1:0]                  out_iterations,
  output logic                                   out_inside_res,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [IDX_W-1:0]                       cfg_idx,
  input  logic [((ITER_BITS > STEP_BITS) ? ITER_BITS : STEP_BITS)-1:0] cfg_wdata
);

  localparam int CFG_W = (ITER_BITS > STEP_BITS) ? ITER_BITS : STEP_BITS;

  logic signed [ORIGIN_BITS-1:0] origin_x_w, origin_y_w;
  logic [STEP_BITS-1:0]          step_x_w, step_y_w;
  logic [ITER_BITS-1:0]          max_iter_w;
  logic [31:0]                   max_ext;
  met_cmd_t                      cmd;
  met_sts_t                      sts;

  assign cfg_ready = 1'b1;
  assign max_ext   = 32'(max_iter_w);

  met_cfg #(
    .ITER_BITS (ITER_BITS),
    .CFG_W     (CFG_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .origin_x  (origin_x_w),
    .origin_y  (origin_y_w),
    .step_x    (step_x_w),
    .step_y    (step_y_w),
    .max_iter  (max_iter_w)
  );

  met_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  met_dp #(
    .PIXEL_BITS (PIXEL_BITS),
    .ITER_BITS  (ITER_BITS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .sts        (sts),
    .pixel_x    (in_pixel_x),
    .pixel_y    (in_pixel_y),
    .origin_x   (origin_x_w),
    .origin_y   (origin_y_w),
    .step_x     (step_x_w),
    .step_y     (step_y_w),
    .max_iter   (max_iter_w),
    .iterations (out_iterations),
    .inside_res (out_inside_res)
  );

  // an accepted pixel keeps the input side busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held busy after accepting a word");

  // loading a result returns the sequencer to idle at once
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result presented while sequencer still busy");

  a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inside_res) |-> (out_iterations == max_ext[OUT_ITER_W-1:0]))
    else $error("inside flag set with count below the limit");

endmodule

// File: tb/tb_mandelbrot_escape_time_top.sv
// Self-checking testbench for mandelbrot_escape_time_top: register setup, escape-count
// prediction per pixel, random stalls on both channels and a long output hold-off.
// Depends on met_pkg and the design files of the block.
module tb_mandelbrot_escape_time_top;
  import met_pkg::*;

  localparam int PIXEL_BITS = 12;
  localparam int ITER_BITS  = 16;
  localparam int WDATA_W    = (ITER_BITS > STEP_BITS) ? ITER_BITS : STEP_BITS;
  localparam longint STEP_MAX  = (longint'(1) << STEP_BITS) - 1;
  localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
  localparam longint PIX_MAX   = (longint'(1) << PIXEL_BITS) - 1;
  localparam longint ITER_MAX  = (longint'(1) << ITER_BITS) - 1;
  localparam int RAND_FRAMES   = 10;
  localparam int FRAME_PIXELS  = 100;

  typedef logic signed [2*COORD_W+1:0] wide_t;
  localparam wide_t ESCAPE_SQ = wide_t'(1) <<< (2 * FRAC_BITS + 2);

  typedef struct packed {
    logic [OUT_ITER_W-1:0] iters;
    logic                  in_set;
  } escape_word_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIXEL_BITS-1:0] in_pixel_x = '0;
  logic [PIXEL_BITS-1:0] in_pixel_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_ITER_W-1:0] out_iterations;
  logic                  out_inside_res;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_idx = '0;
  logic [WDATA_W-1:0]    cfg_wdata = '0;

  // register image as the block should hold it
  longint org_x_q    = 0;
  longint org_y_q    = 0;
  longint step_x_q   = RST_STEP;
  longint step_y_q   = RST_STEP;
  longint iter_lim_q = RST_MAX_ITER;

  escape_word_t pending_words[$];
  int           err_cnt = 0;
  bit           idle_en = 1'b1;
  int           out_hold_req = 0;

  mandelbrot_escape_time_top #(
    .PIXEL_BITS(PIXEL_BITS),
    .ITER_BITS (ITER_BITS)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_iterations(out_iterations),
    .out_inside_res(out_inside_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_idx       (cfg_idx),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic coord_t clamp_coord(input wide_t v);
    if (v > wide_t'(COORD_MAX)) begin
      return COORD_MAX;
    end
    if (v < wide_t'(COORD_MIN)) begin
      return COORD_MIN;
    end
    return coord_t'(v);
  endfunction

  function automatic coord_t pixel_to_coord(input logic [PIXEL_BITS-1:0] pix,
                                            input longint org, input longint stp);
    return clamp_coord(wide_t'(longint'(pix) - org) * wide_t'(stp));
  endfunction

  function automatic escape_word_t predict_escape(input logic [PIXEL_BITS-1:0] px,
                                                  input logic [PIXEL_BITS-1:0] py);
    coord_t       cx, cy, zx, zy;
    wide_t        xx, yy, xy;
    longint       n;
    escape_word_t w;
    cx = pixel_to_coord(px, org_x_q, step_x_q);
    cy = pixel_to_coord(py, org_y_q, step_y_q);
    zx = cx;
    zy = cy;
    n  = 0;
    forever begin
      xx = wide_t'(zx) * wide_t'(zx);
      yy = wide_t'(zy) * wide_t'(zy);
      // a magnitude of exactly 4 still counts as bounded
      if (n >= iter_lim_q || xx + yy > ESCAPE_SQ) begin
        break;
      end
      xy = wide_t'(zx) * wide_t'(zy);
      zx = clamp_coord(((xx - yy) >>> FRAC_BITS) + wide_t'(cx));
      zy = clamp_coord(((xy <<< 1) >>> FRAC_BITS) + wide_t'(cy));
      n++;
    end
    w.iters  = n[OUT_ITER_W-1:0];
    w.in_set = (n == iter_lim_q);
    return w;
  endfunction

  // Leaves cfg_valid high so that back-to-back writes keep one assignment per step.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [WDATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X: org_x_q    = longint'(signed'(data[ORIGIN_BITS-1:0]));
      REG_ORIGIN_Y: org_y_q    = longint'(signed'(data[ORIGIN_BITS-1:0]));
      REG_STEP_X:   step_x_q   = data[STEP_BITS-1:0];
      REG_STEP_Y:   step_y_q   = data[STEP_BITS-1:0];
      REG_MAX_ITER: iter_lim_q = data[ITER_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input longint ox, input longint oy, input longint sx,
                              input longint sy, input longint lim);
    write_reg(REG_ORIGIN_X, WDATA_W'(ox));
    write_reg(REG_ORIGIN_Y, WDATA_W'(oy));
    write_reg(REG_STEP_X, WDATA_W'(sx));
    write_reg(REG_STEP_Y, WDATA_W'(sy));
    write_reg(REG_MAX_ITER, WDATA_W'(lim));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Leaves in_valid high; it drops only for an idle burst or when draining.
  task automatic send_pixel(input longint px, input longint py);
    int gap;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= PIXEL_BITS'(px);
    in_pixel_y <= PIXEL_BITS'(py);
    do @(posedge clk); while (in_stall);
    pending_words.push_back(predict_escape(PIXEL_BITS'(px), PIXEL_BITS'(py)));
  endtask

  task automatic wait_all_words();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_config();
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    send_pixel('haaa, 'h555);
    send_pixel('h555, 'haaa);
    send_pixel(1024, 0);
    wait_all_words();
  endtask

  // c beyond the Q4 range on both axes, both signs, widest step code
  task automatic test_saturation();
    program_regs(-4096, 4095, ONE_Q, STEP_MAX, 8);
    send_pixel(PIX_MAX, 0);
    send_pixel(0, PIX_MAX);
    wait_all_words();
  endtask

  task automatic test_zero_step();
    program_regs(0, 0, 0, RST_STEP, 64);
    send_pixel(PIX_MAX, 0);
    send_pixel(123, 300);
    wait_all_words();
  endtask

  task automatic test_zero_limit();
    program_regs(0, 0, RST_STEP, RST_STEP, 0);
    send_pixel(0, 0);
    send_pixel(PIX_MAX, PIX_MAX);
    wait_all_words();
  endtask

  // c = -2 sits on |z|^2 = 4 forever; c = 2 and c = 2i touch it once
  task automatic test_exact_boundary();
    program_regs(2, 0, ONE_Q, ONE_Q, 32);
    send_pixel(0, 0);
    send_pixel(4, 0);
    send_pixel(2, 2);
    wait_all_words();
  endtask

  task automatic test_limit_extremes();
    program_regs(0, 0, RST_STEP, RST_STEP, 1);
    send_pixel(0, 0);
    send_pixel(300, 0);
    wait_all_words();
    program_regs(0, 0, RST_STEP, RST_STEP, ITER_MAX);
    send_pixel(0, 0);
    send_pixel(300, 0);
    wait_all_words();
  endtask

  task automatic test_unknown_index();
    program_regs(100, -50, RST_STEP >> 1, RST_STEP, 40);
    for (int i = REG_MAX_ITER + 1; i < 2 ** IDX_W; i++) begin
      write_reg(IDX_W'(i), WDATA_W'($urandom));
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    send_pixel(100, 0);
    send_pixel(0, 0);
    wait_all_words();
  endtask

  // Hold the output long enough that the block fills and stalls its input.
  task automatic test_output_hold();
    idle_en = 1'b0;
    program_regs(2048, 2048, RST_STEP, RST_STEP, 4);
    out_hold_req = 400;
    for (int i = 0; i < 12; i++) begin
      send_pixel($urandom_range(0, PIX_MAX), $urandom_range(0, PIX_MAX));
    end
    wait_all_words();
    idle_en = 1'b1;
  endtask

  task automatic test_random_frames();
    longint ox, oy, sx, sy, lim, px, py;
    int     r;
    bit     zoom;
    for (int f = 0; f < RAND_FRAMES; f++) begin
      // the last frames run with no idling on either side
      idle_en = (f < RAND_FRAMES - 2);
      zoom = ($urandom_range(0, 3) != 0);
      r = 1 << $urandom_range(0, 11);
      if (zoom) begin
        // window of +-r pixels spans roughly +-2 around the origin
        ox = $urandom_range(0, PIX_MAX);
        oy = $urandom_range(0, PIX_MAX);
        sx = (longint'(1) << (FRAC_BITS + 1)) / r;
        if (sx > STEP_MAX) begin
          sx = STEP_MAX;
        end
        sx = sx - longint'($urandom_range(0, int'(sx >> 3)));
        sy = sx;
      end else begin
        ox = longint'($urandom_range(0, 8191)) - 4096;
        oy = longint'($urandom_range(0, 8191)) - 4096;
        sx = $urandom_range(0, int'(STEP_MAX));
        sy = $urandom_range(0, int'(STEP_MAX));
      end
      case ($urandom_range(0, 9))
        0:       lim = 0;
        1, 2, 3: lim = $urandom_range(1, 16);
        4, 5, 6: lim = $urandom_range(17, 96);
        default: lim = $urandom_range(97, 256);
      endcase
      program_regs(ox, oy, sx, sy, lim);
      for (int i = 0; i < FRAME_PIXELS; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          px = $urandom_range(0, PIX_MAX);
          py = $urandom_range(0, PIX_MAX);
        end else begin
          px = ox + longint'($urandom_range(0, 2 * r)) - r;
          py = oy + longint'($urandom_range(0, 2 * r)) - r;
          px = (px < 0) ? 0 : ((px > PIX_MAX) ? PIX_MAX : px);
          py = (py < 0) ? 0 : ((py > PIX_MAX) ? PIX_MAX : py);
        end
        send_pixel(px, py);
      end
      wait_all_words();
    end
  endtask

  // output stall: random bursts, or one long hold when a test asks for it
  initial begin : stall_gen
    int n;
    forever begin
      @(posedge clk);
      if (out_hold_req != 0) begin
        n = out_hold_req;
        out_hold_req = 0;
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : word_check
    escape_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: iterations %0d, inside_res %0d",
               out_iterations, out_inside_res);
        err_cnt++;
      end else begin
        want = pending_words.pop_front();
        if (out_iterations !== want.iters) begin
          $error("iterations: expected %0d, actual %0d", want.iters, out_iterations);
          err_cnt++;
        end
        if (out_inside_res !== want.in_set) begin
          $error("inside_res: expected %0d, actual %0d", want.in_set, out_inside_res);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_saturation();
    test_zero_step();
    test_zero_limit();
    test_exact_boundary();
    test_limit_extremes();
    test_unknown_index();
    test_output_hold();
    test_random_frames();
    if (err_cnt == 0) begin
      $display("mandelbrot_escape_time_top test passed");
    end else begin
      $display("mandelbrot_escape_time_top test failed");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("mandelbrot_escape_time_top test failed");
    $finish;
  end

endmodule

// File: mandelbrot_escape_time_top.f
design/met_pkg.sv
design/met_cfg.sv
design/met_ctrl.sv
design/met_dp.sv
design/mandelbrot_escape_time_top.sv
tb/tb_mandelbrot_escape_time_top.sv
